// ----- rtl/psched_pkg.sv -----
`timescale 1ns / 1ps

package psched_pkg;

    // Table geometry and field widths.
    localparam int SLOTS           = 16;
    localparam int SLOT_BITS       = $clog2(SLOTS);
    localparam int SLOT_FIELD_BITS = 4;
    localparam int TIME_BITS       = 16;
    localparam int URG_BITS        = 8;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_DATA_BITS  = SLOT_FIELD_BITS + 2 * TIME_BITS + URG_BITS;
    localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = SLOT_FIELD_BITS + 1 + 4 * TIME_BITS;
    localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Item kinds carried on the input tuser.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EXEC = 3'b100
    } state_t;

    // Time step that holds at the maximum.
    function automatic logic [TIME_BITS-1:0] time_inc(input logic [TIME_BITS-1:0] t);
        logic [TIME_BITS-1:0] r;
        r = (t == TIME_MAX) ? TIME_MAX : t + 1'b1;
        return r;
    endfunction

endpackage

// ----- rtl/preemptive_priority_scheduler_top.sv -----
`timescale 1ns / 1ps

// Preemptive priority scheduler over a table of sixteen task slots. A load
// transfer (tuser = 0) writes one slot's arrival, burst and urgency and
// returns a registered idle result. A tick transfer (tuser = 1) scans
// the slots one per cycle through a single compare unit to find the ready
// task with the lowest urgency (ties to earlier arrival, then lower slot),
// then, in the exec state, runs it for one time unit and forms its
// response, turnaround and waiting times (the last two once it finishes),
// or an idle result if none is ready. A tick holds off the input through
// the scan and exec states. The input is ready only while the sequencer
// is idle and the output register is free or being emptied. The time
// counter holds at its maximum value.
module preemptive_priority_scheduler_top
    import psched_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: slot[3:0], arrival[19:4], burst[35:20], urgency[43:36].
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // Fields: mode (0 load, 1 tick).
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: running_slot[3:0], finished[4], tick_time[20:5],
    // response_time[36:21], turnaround_time[52:37], waiting_time[68:53].
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // Fields: idle.
    output logic                   m_tuser
);

    // Input field unpacking.
    logic [SLOT_FIELD_BITS-1:0] in_slot;
    logic [TIME_BITS-1:0]       in_arrival;
    logic [TIME_BITS-1:0]       in_burst;
    logic [URG_BITS-1:0]        in_urgency;

    assign in_slot    = s_tdata[SLOT_FIELD_BITS-1:0];
    assign in_arrival = s_tdata[SLOT_FIELD_BITS +: TIME_BITS];
    assign in_burst   = s_tdata[SLOT_FIELD_BITS + TIME_BITS +: TIME_BITS];
    assign in_urgency = s_tdata[SLOT_FIELD_BITS + 2 * TIME_BITS +: URG_BITS];

    // Task tables.
    logic [TIME_BITS-1:0] arrival_reg   [SLOTS];
    logic [TIME_BITS-1:0] burst_reg     [SLOTS];
    logic [URG_BITS-1:0]  urgency_reg   [SLOTS];
    logic [TIME_BITS-1:0] remaining_reg [SLOTS];
    logic [TIME_BITS-1:0] start_reg     [SLOTS];
    logic [SLOTS-1:0]     valid_reg;
    logic [SLOTS-1:0]     started_reg;

    // Sequencer and scan state.
    state_t               state_reg, state_next;
    logic [TIME_BITS-1:0] now_reg;
    logic [SLOT_BITS-1:0] scan_idx_reg;
    logic                 found_reg;
    logic [SLOT_BITS-1:0] best_idx_reg;
    logic [URG_BITS-1:0]  best_urg_reg;
    logic [TIME_BITS-1:0] best_arr_reg;

    // Output register.
    logic                       out_valid_reg;
    logic                       out_idle_reg;
    logic [SLOT_FIELD_BITS-1:0] out_slot_reg;
    logic                       out_fin_reg;
    logic [TIME_BITS-1:0]       out_tick_reg;
    logic [TIME_BITS-1:0]       out_resp_reg;
    logic [TIME_BITS-1:0]       out_tat_reg;
    logic [TIME_BITS-1:0]       out_wt_reg;

    // Handshakes.
    logic out_free;
    logic in_fire;
    logic load_fire;
    logic load_in_range;
    logic [SLOT_BITS-1:0] wr_idx;

    assign out_free      = !out_valid_reg || m_tready;
    assign s_tready      = (state_reg == ST_IDLE) && out_free;
    assign in_fire       = s_tvalid && s_tready;
    assign load_fire     = in_fire && (s_tuser == MODE_LOAD);
    assign load_in_range = (32'(in_slot) < SLOTS);
    assign wr_idx        = SLOT_BITS'(in_slot);

    // Single table read port: the scan slot while scanning, else the pick.
    logic [SLOT_BITS-1:0] rd_idx;
    logic [TIME_BITS-1:0] rd_arr;
    logic [TIME_BITS-1:0] rd_burst;
    logic [URG_BITS-1:0]  rd_urg;
    logic [TIME_BITS-1:0] rd_rem;
    logic [TIME_BITS-1:0] rd_start;
    logic                 rd_valid;
    logic                 rd_started;

    assign rd_idx     = (state_reg == ST_SCAN) ? scan_idx_reg : best_idx_reg;
    assign rd_arr     = arrival_reg[rd_idx];
    assign rd_burst   = burst_reg[rd_idx];
    assign rd_urg     = urgency_reg[rd_idx];
    assign rd_rem     = remaining_reg[rd_idx];
    assign rd_start   = start_reg[rd_idx];
    assign rd_valid   = valid_reg[rd_idx];
    assign rd_started = started_reg[rd_idx];

    // Shared compare unit: is the scanned slot ready and better than the best so far.
    logic eligible;
    logic better;

    assign eligible = rd_valid && (rd_rem != '0) && (rd_arr <= now_reg);
    assign better   = !found_reg || (rd_urg < best_urg_reg) ||
                      ((rd_urg == best_urg_reg) && (rd_arr < best_arr_reg));

    // Run arithmetic for the picked slot.
    logic [TIME_BITS-1:0] run_start;
    logic [TIME_BITS-1:0] run_resp;
    logic [TIME_BITS-1:0] run_rem;
    logic                 run_fin;
    logic [TIME_BITS-1:0] run_ct;
    logic [TIME_BITS-1:0] run_tat;
    logic [TIME_BITS-1:0] run_wt;

    assign run_start = rd_started ? rd_start : now_reg;
    assign run_resp  = run_start - rd_arr;
    assign run_rem   = rd_rem - 1'b1;
    assign run_fin   = (run_rem == '0);
    assign run_ct    = time_inc(now_reg);
    assign run_tat   = run_ct - rd_arr;
    assign run_wt    = (run_tat >= rd_burst) ? run_tat - rd_burst : '0;

    // Sequencer transitions.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (s_tuser == MODE_TICK))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == SLOT_BITS'(SLOTS - 1))
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            scan_idx_reg  <= '0;
            found_reg     <= 1'b0;
            valid_reg     <= '0;
            started_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // The result register fills on a load or at the end of a tick
            // and empties on an output transfer.
            if (load_fire || (state_reg == ST_EXEC))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    scan_idx_reg <= '0;
                    found_reg    <= 1'b0;
                    if (load_fire && load_in_range)
                    begin
                        valid_reg[wr_idx]   <= 1'b1;
                        started_reg[wr_idx] <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                    if (eligible && better)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                ST_EXEC:
                begin
                    now_reg <= time_inc(now_reg);
                    if (found_reg)
                    begin
                        started_reg[best_idx_reg] <= 1'b1;
                    end
                end
                default:
                begin
                    scan_idx_reg <= '0;
                end
            endcase
        end
    end

    // Tables, best candidate and result payload.
    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            out_idle_reg <= 1'b1;
            out_slot_reg <= '0;
            out_fin_reg  <= 1'b0;
            out_tick_reg <= '0;
            out_resp_reg <= '0;
            out_tat_reg  <= '0;
            out_wt_reg   <= '0;
            if (load_in_range)
            begin
                arrival_reg[wr_idx]   <= in_arrival;
                burst_reg[wr_idx]     <= in_burst;
                urgency_reg[wr_idx]   <= in_urgency;
                remaining_reg[wr_idx] <= in_burst;
            end
        end

        if ((state_reg == ST_SCAN) && eligible && better)
        begin
            best_idx_reg <= scan_idx_reg;
            best_urg_reg <= rd_urg;
            best_arr_reg <= rd_arr;
        end

        if (state_reg == ST_EXEC)
        begin
            out_tick_reg <= now_reg;
            if (found_reg)
            begin
                out_idle_reg <= 1'b0;
                out_slot_reg <= SLOT_FIELD_BITS'(best_idx_reg);
                out_fin_reg  <= run_fin;
                out_resp_reg <= run_resp;
                out_tat_reg  <= run_fin ? run_tat : '0;
                out_wt_reg   <= run_fin ? run_wt : '0;
                remaining_reg[best_idx_reg] <= run_rem;
                if (!rd_started)
                begin
                    start_reg[best_idx_reg] <= now_reg;
                end
            end
            else
            begin
                out_idle_reg <= 1'b1;
                out_slot_reg <= '0;
                out_fin_reg  <= 1'b0;
                out_resp_reg <= '0;
                out_tat_reg  <= '0;
                out_wt_reg   <= '0;
            end
        end
    end

    // Output packing.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_idle_reg;
    assign m_tdata  = OUT_TDATA_W'({out_wt_reg, out_tat_reg, out_resp_reg,
                                    out_tick_reg, out_fin_reg, out_slot_reg});

endmodule
